### sv/hmtp_pkg.sv
// Shared types and constants of the height map token parser.
`default_nettype none
package hmtp_pkg;

	// Register file
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int MAPW_W = 13;
	localparam int MAPH_W = 17;
	localparam logic REG_MAP_WIDTH  = 1'b0;
	localparam logic REG_MAP_HEIGHT = 1'b1;

	// Queue depth between stages (power of two)
	localparam int QUEUE_DEPTH = 2;

	// Characters
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_1     = 8'h31;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	localparam logic [31:0] DEFAULT_COLOR = 32'h77FF_FFFF;

	// Character classes produced by the front end
	typedef enum logic [3:0] {
		CLS_NUL,
		CLS_SPACE,
		CLS_PLUS,
		CLS_MINUS,
		CLS_ZERO,
		CLS_DIGIT,
		CLS_HEXAF,
		CLS_X,
		CLS_COMMA,
		CLS_OTHER
	} cls_t;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		cls_t       cls;
		logic [3:0] val;
		logic       last;
	} cls_word_t;

	typedef struct packed {
		logic [11:0]        col_x;
		logic [15:0]        row_y;
		logic signed [31:0] height_z;
		logic [31:0]        point_color;
		logic               parse_error;
		logic               is_last;
	} out_word_t;

endpackage
`default_nettype wire

### sv/height_map_token_parser.sv
// Height map token parser top level: register port, front end, queues, back end.
// Each byte is registered in the input queue and its result in the output queue.
// Throughput: one byte per cycle while the output queue is not full.
// Two-entry queues sit before and after the back end, so each side stalls on its own.
// Reset clears both queues, the parser, the cursor and the error flag.
// Reset sets map width and map height to one.
`default_nettype none
module height_map_token_parser
	import hmtp_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire in_word_t          din,
	output logic                   full,
	input  wire logic              pop,
	output out_word_t              dout,
	output logic                   empty,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0]      prdata,
	output logic                   pready
);

	logic [MAPW_W-1:0] map_width_q;
	logic [MAPH_W-1:0] map_height_q;
	logic              reg_idx;

	cls_word_t cw_in, cw_q;
	out_word_t ow;
	logic      q_empty, q_pop, out_full, out_push;

	assign pready  = 1'b1;
	assign reg_idx = paddr[2];

	// Write registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= MAPW_W'(1);
			map_height_q <= MAPH_W'(1);
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_MAP_WIDTH:  map_width_q  <= pwdata[MAPW_W-1:0];
				REG_MAP_HEIGHT: map_height_q <= pwdata[MAPH_W-1:0];
				default: ;
			endcase
		end
	end

	// Read registers
	always_comb begin
		unique case (reg_idx)
			REG_MAP_WIDTH:  prdata = DATA_W'(map_width_q);
			REG_MAP_HEIGHT: prdata = DATA_W'(map_height_q);
			default:        prdata = '0;
		endcase
	end

	hmtp_front u_front (
		.din (din),
		.cw  (cw_in)
	);

	hmtp_fifo #(
		.W ($bits(cls_word_t))
	) u_in_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cw_in),
		.full   (full),
		.pop    (q_pop),
		.rdata  (cw_q),
		.empty  (q_empty)
	);

	hmtp_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.qw         (cw_q),
		.q_empty    (q_empty),
		.q_pop      (q_pop),
		.out_full   (out_full),
		.out_push   (out_push),
		.ow         (ow),
		.map_width  (map_width_q),
		.map_height (map_height_q)
	);

	hmtp_fifo #(
		.W ($bits(out_word_t))
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (ow),
		.full   (out_full),
		.pop    (pop),
		.rdata  (dout),
		.empty  (empty)
	);

	// A result is only formed from a word taken off the input queue
	a_push_needs_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> q_pop)
		else $error("result pushed without consuming a byte");

	// The back end never takes a word from an empty queue or into a full one
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!q_empty && !out_full))
		else $error("back end stepped while stalled");

	// End of text always yields exactly one result word marked last
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && cw_q.last) |-> (out_push && ow.is_last))
		else $error("end of text produced no final word");

endmodule
`default_nettype wire

### sv/hmtp_fifo.sv
// Small register queue used between the parser stages.
`default_nettype none
module hmtp_fifo
	import hmtp_pkg::*;
#(
	parameter int W = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	logic [W-1:0] mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [PW:0] cnt_q;
	logic push_ok, pop_ok;

	assign full    = (cnt_q == (PW+1)'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= wr_q + PW'(1);
			end
			if (pop_ok) begin
				rd_q <= rd_q + PW'(1);
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + (PW+1)'(1);
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - (PW+1)'(1);
			end
		end
	end

endmodule
`default_nettype wire

### sv/hmtp_front.sv
// Front end: classifies each text byte into a character class and value.
`default_nettype none
module hmtp_front
	import hmtp_pkg::*;
(
	input  wire in_word_t din,
	output cls_word_t     cw
);

	logic [7:0] b;

	assign b = din.text_byte;

	// Classify the byte
	always_comb begin
		cw.val  = b[3:0];
		cw.last = din.end_of_text || (b == CH_NUL);
		priority if (b == CH_NUL) begin
			cw.cls = CLS_NUL;
		end else if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
			cw.cls = CLS_SPACE;
		end else if (b == CH_PLUS) begin
			cw.cls = CLS_PLUS;
		end else if (b == CH_MINUS) begin
			cw.cls = CLS_MINUS;
		end else if (b == CH_0) begin
			cw.cls = CLS_ZERO;
		end else if (b >= CH_1 && b <= CH_9) begin
			cw.cls = CLS_DIGIT;
		end else if ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF)) begin
			cw.cls = CLS_HEXAF;
			cw.val = b[3:0] + 4'd9;
		end else if (b == CH_LX || b == CH_UX) begin
			cw.cls = CLS_X;
		end else if (b == CH_COMMA) begin
			cw.cls = CLS_COMMA;
		end else begin
			cw.cls = CLS_OTHER;
		end
	end

endmodule
`default_nettype wire

### sv/hmtp_back.sv
// Back end: token state machine, grid cursor and result formation.
`default_nettype none
module hmtp_back
	import hmtp_pkg::*;
#(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 65536
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cls_word_t         qw,
	input  wire logic              q_empty,
	output logic                   q_pop,
	input  wire logic              out_full,
	output logic                   out_push,
	output out_word_t              ow,
	input  wire logic [MAPW_W-1:0] map_width,
	input  wire logic [MAPH_W-1:0] map_height
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = (CW + 1 > MAPW_W) ? CW + 1 : MAPW_W;
	localparam int HW = (RW + 1 > MAPH_W) ? RW + 1 : MAPH_W;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SIGN   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_COMMA  = 3'd3;
	localparam logic [2:0] PH_ZERO   = 3'd4;
	localparam logic [2:0] PH_HEX    = 3'd5;

	typedef struct packed {
		logic [2:0]  ph;
		logic [31:0] h;
		logic        ng;
		logic [31:0] cc;
		logic        er;
	} prs_t;

	function automatic prs_t clear_tok(prs_t p);
		prs_t r;
		r    = p;
		r.ph = PH_IDLE;
		r.h  = '0;
		r.ng = 1'b0;
		r.cc = '0;
		return r;
	endfunction

	function automatic prs_t idle_step(prs_t p, cls_t c, logic [3:0] v);
		prs_t r;
		r = p;
		unique case (c)
			CLS_SPACE: ;
			CLS_PLUS, CLS_MINUS: begin
				r.ng = (c == CLS_MINUS);
				r.ph = PH_SIGN;
			end
			CLS_ZERO, CLS_DIGIT: begin
				r.h  = 32'(v);
				r.ph = PH_DIGITS;
			end
			default: r.er = 1'b1;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] signed_h(prs_t p);
		return p.ng ? (32'd0 - p.h) : p.h;
	endfunction

	logic [2:0]    ph_q;
	logic [31:0]   h_q, cc_q;
	logic          neg_q, err_q, full_q;
	logic [CW-1:0] col_q, col_n;
	logic [RW-1:0] row_q, row_n;
	logic          full_n;

	prs_t        p;
	logic        redo, fin, emit, step, is_dig, is_hex;
	logic [31:0] fz, fc, col_ext, row_ext;
	logic [WW-1:0] w_raw, w_eff;
	logic [HW-1:0] h_raw, h_eff;

	assign step   = !q_empty && !out_full;
	assign q_pop  = step;
	assign is_dig = (qw.cls == CLS_ZERO) || (qw.cls == CLS_DIGIT);
	assign is_hex = is_dig || (qw.cls == CLS_HEXAF);

	// Clamp the configured map size
	always_comb begin
		w_raw = WW'(map_width);
		h_raw = HW'(map_height);
		priority if (w_raw == '0) begin
			w_eff = WW'(1);
		end else if (w_raw > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = w_raw;
		end
		priority if (h_raw == '0) begin
			h_eff = HW'(1);
		end else if (h_raw > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = h_raw;
		end
	end

	// Parse one classified byte, then flush on end of text
	always_comb begin
		p    = '{ph: ph_q, h: h_q, ng: neg_q, cc: cc_q, er: err_q};
		redo = 1'b0;
		fin  = 1'b0;
		fz   = '0;
		fc   = '0;
		if (qw.cls != CLS_NUL) begin
			unique case (p.ph)
				PH_SIGN: begin
					if (is_dig) begin
						p.h  = 32'(qw.val);
						p.ph = PH_DIGITS;
					end else begin
						p.er = 1'b1;
						p    = clear_tok(p);
						redo = 1'b1;
					end
				end
				PH_DIGITS: begin
					if (is_dig) begin
						p.h = (p.h << 3) + (p.h << 1) + 32'(qw.val);
					end else if (qw.cls == CLS_COMMA) begin
						p.ph = PH_COMMA;
					end else begin
						fin  = 1'b1;
						fz   = signed_h(p);
						fc   = DEFAULT_COLOR;
						p    = clear_tok(p);
						redo = 1'b1;
					end
				end
				PH_COMMA: begin
					if (qw.cls == CLS_ZERO) begin
						p.ph = PH_ZERO;
					end else begin
						p.er = 1'b1;
						fin  = 1'b1;
						fz   = signed_h(p);
						fc   = DEFAULT_COLOR;
						p    = clear_tok(p);
					end
				end
				PH_ZERO: begin
					if (qw.cls == CLS_X) begin
						p.cc = '0;
						p.ph = PH_HEX;
					end else begin
						p.er = 1'b1;
						fin  = 1'b1;
						fz   = signed_h(p);
						fc   = DEFAULT_COLOR;
						p    = clear_tok(p);
					end
				end
				PH_HEX: begin
					if (is_hex) begin
						p.cc = {p.cc[27:0], qw.val};
					end else begin
						fin  = 1'b1;
						fz   = signed_h(p);
						fc   = p.cc;
						p    = clear_tok(p);
						redo = 1'b1;
					end
				end
				default: p = idle_step(p, qw.cls, qw.val);
			endcase
			if (redo) begin
				p = idle_step(p, qw.cls, qw.val);
			end
		end
		// A token finished above leaves the phase idle or at a sign
		if (qw.last) begin
			unique case (p.ph)
				PH_SIGN: p.er = 1'b1;
				PH_DIGITS: begin
					fin = 1'b1;
					fz  = signed_h(p);
					fc  = DEFAULT_COLOR;
				end
				PH_COMMA, PH_ZERO: begin
					p.er = 1'b1;
					fin  = 1'b1;
					fz   = signed_h(p);
					fc   = DEFAULT_COLOR;
				end
				PH_HEX: begin
					fin = 1'b1;
					fz  = signed_h(p);
					fc  = p.cc;
				end
				default: ;
			endcase
		end
	end

	// Place the point and advance the cursor
	always_comb begin
		emit   = fin && !full_q;
		col_n  = col_q;
		row_n  = row_q;
		full_n = full_q;
		if (emit) begin
			if (WW'(col_q) + WW'(1) >= w_eff) begin
				col_n = '0;
				if (HW'(row_q) + HW'(1) >= h_eff) begin
					full_n = 1'b1;
				end else begin
					row_n = row_q + RW'(1);
				end
			end else begin
				col_n = col_q + CW'(1);
			end
		end
	end

	// Form the result word
	always_comb begin
		col_ext        = 32'(col_q);
		row_ext        = 32'(row_q);
		out_push       = step && (emit || qw.last);
		ow.col_x       = emit ? col_ext[11:0] : '0;
		ow.row_y       = emit ? row_ext[15:0] : '0;
		ow.height_z    = emit ? fz : '0;
		ow.point_color = emit ? fc : '0;
		ow.parse_error = p.er;
		ow.is_last     = qw.last;
	end

	// Update state; end of text returns everything to the start of a text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_IDLE;
			h_q    <= '0;
			neg_q  <= 1'b0;
			cc_q   <= '0;
			err_q  <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
			full_q <= 1'b0;
		end else if (step) begin
			if (qw.last) begin
				ph_q   <= PH_IDLE;
				h_q    <= '0;
				neg_q  <= 1'b0;
				cc_q   <= '0;
				err_q  <= 1'b0;
				col_q  <= '0;
				row_q  <= '0;
				full_q <= 1'b0;
			end else begin
				ph_q   <= p.ph;
				h_q    <= p.h;
				neg_q  <= p.ng;
				cc_q   <= p.cc;
				err_q  <= p.er;
				col_q  <= col_n;
				row_q  <= row_n;
				full_q <= full_n;
			end
		end
	end

endmodule
`default_nettype wire
